/* design/apbb_pkg.sv */
// ============================================================================
// apbb_pkg
// Shared types and constants for the arm position bang-bang controller.
// ============================================================================
package apbb_pkg;

  // Field widths
  localparam int ANGLE_W = 16;
  localparam int ERR_W   = 17;
  localparam int PWR_W   = 7;
  localparam int CMD_W   = 8;
  localparam int TICK_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_POWER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MAX    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MIN    = 2'd3;

  // Register reset values
  localparam logic signed [ANGLE_W-1:0] TARGET_RST    = 16'sd0;
  localparam logic [PWR_W-1:0]          DRIVE_PWR_RST = 7'd50;
  localparam logic signed [ANGLE_W-1:0] LIMIT_MAX_RST = 16'sh7fff;
  localparam logic signed [ANGLE_W-1:0] LIMIT_MIN_RST = 16'sh8000;

  // Control phase codes
  localparam logic [1:0] PH_LOAD  = 2'd0;
  localparam logic [1:0] PH_MOVE  = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;
  localparam logic [1:0] PH_SPARE = 2'd3;

  // Input function codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_STOP = 1'b1;

  // Dead band half width
  localparam logic signed [ERR_W-1:0] BAND_HI = 17'sd2;
  localparam logic signed [ERR_W-1:0] BAND_LO = -17'sd2;

  // Configuration register set
  typedef struct packed {
    logic signed [ANGLE_W-1:0] target_angle;
    logic [PWR_W-1:0]          drive_power;
    logic signed [ANGLE_W-1:0] limit_max;
    logic signed [ANGLE_W-1:0] limit_min;
  } cfg_t;

  // Controller state
  typedef struct packed {
    logic [1:0]                phase;
    logic [TICK_W-1:0]         tick_count;
    logic signed [ANGLE_W-1:0] clamped_target;
    logic signed [ERR_W-1:0]   last_error;
    logic signed [CMD_W-1:0]   power_held;
    logic                      brake_held;
    logic                      done_flag;
    logic [PWR_W-1:0]          run_power;
  } state_t;

endpackage

/* design/apbb_if.sv */
// ============================================================================
// apbb_in_if / apbb_out_if
// Valid/ready channels for encoder ticks in and motor commands out.
// ============================================================================
interface apbb_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic signed [apbb_pkg::ANGLE_W-1:0] encoder_angle;

  modport source (output valid, output func, output encoder_angle, input ready);
  modport sink   (input valid, input func, input encoder_angle, output ready);
endinterface

interface apbb_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [apbb_pkg::CMD_W-1:0] motor_power;
  logic                              brake_on;
  logic                              finished;

  modport source (output valid, output motor_power, output brake_on, output finished,
                  input ready);
  modport sink   (input valid, input motor_power, input brake_on, input finished,
                  output ready);
endinterface

/* design/arm_position_bang_bang.sv */
// ============================================================================
// arm_position_bang_bang
// Bang-bang arm position controller with a dead band and stall detection.
// ============================================================================
// Path: an accepted input beat goes into the input register, then through the
// controller logic into the result register; a result-side stall holds it there.
// Throughput: 1 beat per cycle while the result side is not stalled; the state
// update per beat is one 17-bit subtract and a few compares ahead of the result register.
// Reset: synchronous rst_n clears state and pipeline valids and loads the
// config registers with their defaults; a beat can be accepted right after.
module arm_position_bang_bang #(
  parameter int STALL_TICKS = 125
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [apbb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [apbb_pkg::CFG_DATA_W-1:0]       cfg_data,
  apbb_in_if.sink                               in_beat,
  apbb_out_if.source                            out_beat
);

  apbb_pkg::cfg_t   cfg_r;
  apbb_pkg::state_t st_r;
  apbb_pkg::state_t st_nxt;

  logic                                s1_valid_r;
  logic                                s1_func_r;
  logic signed [apbb_pkg::ANGLE_W-1:0] s1_enc_r;
  logic                                out_valid_r;
  logic                                adv;
  logic                                in_acc;

  // Config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_angle <= apbb_pkg::TARGET_RST;
      cfg_r.drive_power  <= apbb_pkg::DRIVE_PWR_RST;
      cfg_r.limit_max    <= apbb_pkg::LIMIT_MAX_RST;
      cfg_r.limit_min    <= apbb_pkg::LIMIT_MIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        apbb_pkg::REG_TARGET_ANGLE: cfg_r.target_angle <= cfg_data;
        apbb_pkg::REG_DRIVE_POWER:  cfg_r.drive_power  <= cfg_data[apbb_pkg::PWR_W-1:0];
        apbb_pkg::REG_LIMIT_MAX:    cfg_r.limit_max    <= cfg_data;
        apbb_pkg::REG_LIMIT_MIN:    cfg_r.limit_min    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Handshake: the stage moves when the result register is free or taken
  assign adv           = !out_valid_r || out_beat.ready;
  assign in_beat.ready = !s1_valid_r || adv;
  assign in_acc        = in_beat.valid && in_beat.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= in_beat.func;
      s1_enc_r  <= in_beat.encoder_angle;
    end
  end

  // Control step
  apbb_ctrl #(
    .STALL_TICKS (STALL_TICKS)
  ) u_ctrl (
    .cfg           (cfg_r),
    .st            (st_r),
    .func          (s1_func_r),
    .encoder_angle (s1_enc_r),
    .st_nxt        (st_nxt)
  );

  // State update, one beat at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_valid_r && adv) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && adv) begin
      out_beat.motor_power <= st_nxt.power_held;
      out_beat.brake_on    <= st_nxt.brake_held;
      out_beat.finished    <= st_nxt.done_flag;
    end
  end

  assign out_beat.valid = out_valid_r;

  // Finished only ever shows with the brake applied
  a_fin_brake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_beat.finished || out_beat.brake_on))
    else $error("finished without brake");

  // A finished move never drives the motor
  a_fin_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_beat.finished) |-> (out_beat.motor_power == '0))
    else $error("motor driven after finish");

  // Once applied, the brake stays on until reset
  a_brake_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.brake_held |=> st_r.brake_held)
    else $error("brake released");

  // A stalled beat in the input register is not lost
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_enc_r) && $stable(s1_func_r)))
    else $error("input register dropped a beat");

endmodule

/* design/apbb_ctrl.sv */
// ============================================================================
// apbb_ctrl
// Next-state logic for one control beat: clamp, error, dead band, stall check.
// ============================================================================
module apbb_ctrl #(
  parameter int STALL_TICKS = 125
) (
  input  apbb_pkg::cfg_t                      cfg,
  input  apbb_pkg::state_t                    st,
  input  logic                                func,
  input  logic signed [apbb_pkg::ANGLE_W-1:0] encoder_angle,
  output apbb_pkg::state_t                    st_nxt
);

  apbb_pkg::state_t                    ld;
  logic signed [apbb_pkg::ANGLE_W-1:0] tgt_clamp;
  logic signed [apbb_pkg::ERR_W-1:0]   err;
  logic                                hit;
  logic                                stalled;
  logic [apbb_pkg::CMD_W-1:0]          pwr_pos;

  // Target clamp; max is checked first when the limits are crossed
  always_comb begin
    if (cfg.target_angle > cfg.limit_max) begin
      tgt_clamp = cfg.limit_max;
    end else if (cfg.target_angle < cfg.limit_min) begin
      tgt_clamp = cfg.limit_min;
    end else begin
      tgt_clamp = cfg.target_angle;
    end
  end

  // State after the load step (load phase falls through into move)
  always_comb begin
    ld = st;
    if (st.phase == apbb_pkg::PH_LOAD) begin
      ld.run_power      = cfg.drive_power;
      ld.clamped_target = tgt_clamp;
      ld.phase          = apbb_pkg::PH_MOVE;
    end
  end

  // Position error, stall tick
  assign err = {ld.clamped_target[apbb_pkg::ANGLE_W-1], ld.clamped_target}
             - {encoder_angle[apbb_pkg::ANGLE_W-1], encoder_angle};
  assign hit     = (ld.tick_count == apbb_pkg::TICK_W'(STALL_TICKS));
  assign stalled = hit && (err == ld.last_error);
  assign pwr_pos = {1'b0, ld.run_power};

  always_comb begin
    st_nxt = ld;
    if (func == apbb_pkg::FUNC_STOP) begin
      st_nxt            = st;
      st_nxt.power_held = '0;
      st_nxt.brake_held = 1'b1;
      st_nxt.tick_count = '0;
      st_nxt.phase      = apbb_pkg::PH_LOAD;
      st_nxt.done_flag  = 1'b0;
    end else begin
      unique case (ld.phase)
        apbb_pkg::PH_MOVE: begin
          st_nxt.tick_count = ld.tick_count + 1'b1;
          if (hit && !stalled) begin
            st_nxt.last_error = err;
            st_nxt.tick_count = '0;
          end
          priority if (stalled) begin
            st_nxt.power_held = '0;
            st_nxt.phase      = apbb_pkg::PH_DONE;
          end else if (err >= apbb_pkg::BAND_LO && err <= apbb_pkg::BAND_HI) begin
            st_nxt.power_held = '0;
            st_nxt.phase      = apbb_pkg::PH_DONE;
          end else if (err > apbb_pkg::BAND_HI) begin
            st_nxt.power_held = pwr_pos;
          end else begin
            st_nxt.power_held = -pwr_pos;
          end
        end
        apbb_pkg::PH_DONE: begin
          st_nxt.brake_held = 1'b1;
          st_nxt.done_flag  = 1'b1;
        end
        default: begin
          // spare phase code: hold
        end
      endcase
    end
  end

endmodule

/* dv/testbench.sv */
// ============================================================================
// testbench
// Self-checking bench for the arm position bang-bang controller. A short
// table of directed beats and register writes runs first. Random phases
// follow, each with fresh register settings and a mix of approach, hover,
// stall and noise sequences. Every result beat is compared field by field
// against an in-bench model of the controller or a command typed into the table.
// ============================================================================
module testbench;

  localparam int STALL_TICKS  = 125;
  localparam int RANDOM_ITEMS = 1300;
  localparam int QUIET_TAIL   = 150;
  localparam int PHASE_ITEMS  = 160;
  localparam int CYCLE_LIMIT  = 500000;

  // One motor command as it leaves the block
  typedef struct packed {
    logic signed [apbb_pkg::CMD_W-1:0] power;
    logic                              brake;
    logic                              done;
  } cmd_t;

  // One input beat
  typedef struct packed {
    logic                                fn;
    logic signed [apbb_pkg::ANGLE_W-1:0] enc;
  } beat_t;

  // Directed table rows: a beat checked by the model, a beat with its
  // command typed in, or a register write
  typedef enum logic [1:0] {ROW_BEAT, ROW_CHECKED, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                          kind;
    logic                               fn;
    logic [apbb_pkg::CFG_DATA_W-1:0]    value;
    logic [apbb_pkg::CFG_IDX_W-1:0]     idx;
    cmd_t                               want;
  } step_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [apbb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [apbb_pkg::CFG_DATA_W-1:0] cfg_data;

  apbb_in_if  in_ch ();
  apbb_out_if out_ch ();

  arm_position_bang_bang #(.STALL_TICKS(STALL_TICKS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_beat  (in_ch),
    .out_beat (out_ch)
  );

  // Model copy of registers and controller state
  apbb_pkg::cfg_t   regs;
  apbb_pkg::state_t ctl;
  cmd_t             pending_cmds[$];
  int               fail_count;
  int               src_gap_pct;
  int               sink_stall_pct;
  int               cycle_count;

  // Directed table; idx is only meaningful on register rows
  step_row_t directed_rows [29] = '{
    // reset settings: target 0, power 50, full limits
    '{ROW_CHECKED, apbb_pkg::FUNC_TICK, 16'h0000, apbb_pkg::REG_TARGET_ANGLE,
      '{8'sd0, 1'b0, 1'b0}},
    '{ROW_CHECKED, apbb_pkg::FUNC_TICK, 16'h1234, apbb_pkg::REG_TARGET_ANGLE,
      '{8'sd0, 1'b1, 1'b1}},
    '{ROW_CHECKED, apbb_pkg::FUNC_STOP, 16'h7fff, apbb_pkg::REG_TARGET_ANGLE,
      '{8'sd0, 1'b1, 1'b0}},
    '{ROW_CHECKED, apbb_pkg::FUNC_TICK, 16'h8000, apbb_pkg::REG_TARGET_ANGLE,
      '{8'sd50, 1'b1, 1'b0}},
    '{ROW_CHECKED, apbb_pkg::FUNC_TICK, 16'h7fff, apbb_pkg::REG_TARGET_ANGLE,
      '{-8'sd50, 1'b1, 1'b0}},
    // band edges
    '{ROW_BEAT,    apbb_pkg::FUNC_TICK, 16'h0003, apbb_pkg::REG_TARGET_ANGLE, '0},
    '{ROW_BEAT,    apbb_pkg::FUNC_TICK, 16'hfffd, apbb_pkg::REG_TARGET_ANGLE, '0},
    '{ROW_BEAT,    apbb_pkg::FUNC_TICK, 16'h0002, apbb_pkg::REG_TARGET_ANGLE, '0},
    '{ROW_BEAT,    apbb_pkg::FUNC_TICK, 16'hffff, apbb_pkg::REG_TARGET_ANGLE, '0},
    '{ROW_BEAT,    apbb_pkg::FUNC_STOP, 16'h0000, apbb_pkg::REG_TARGET_ANGLE, '0},
    '{ROW_BEAT,    apbb_pkg::FUNC_TICK, 16'hfffe, apbb_pkg::REG_TARGET_ANGLE, '0},
    '{ROW_BEAT,    apbb_pkg::FUNC_STOP, 16'h5555, apbb_pkg::REG_TARGET_ANGLE, '0},
    '{ROW_BEAT,    apbb_pkg::FUNC_TICK, 16'haaaa, apbb_pkg::REG_TARGET_ANGLE, '0},
    '{ROW_BEAT,    apbb_pkg::FUNC_STOP, 16'haaaa, apbb_pkg::REG_TARGET_ANGLE, '0},
    // power above 100 and the widest error
    '{ROW_REG,     apbb_pkg::FUNC_TICK, 16'h007f, apbb_pkg::REG_DRIVE_POWER,  '0},
    '{ROW_REG,     apbb_pkg::FUNC_TICK, 16'h7fff, apbb_pkg::REG_TARGET_ANGLE, '0},
    '{ROW_BEAT,    apbb_pkg::FUNC_STOP, 16'h0000, apbb_pkg::REG_TARGET_ANGLE, '0},
    '{ROW_CHECKED, apbb_pkg::FUNC_TICK, 16'h8000, apbb_pkg::REG_TARGET_ANGLE,
      '{8'sd127, 1'b1, 1'b0}},
    // crossed limits: max -100, min 100; a target above max goes to max
    '{ROW_REG,     apbb_pkg::FUNC_TICK, 16'hff9c, apbb_pkg::REG_LIMIT_MAX,    '0},
    '{ROW_REG,     apbb_pkg::FUNC_TICK, 16'h0064, apbb_pkg::REG_LIMIT_MIN,    '0},
    '{ROW_REG,     apbb_pkg::FUNC_TICK, 16'h0000, apbb_pkg::REG_TARGET_ANGLE, '0},
    '{ROW_BEAT,    apbb_pkg::FUNC_STOP, 16'h0000, apbb_pkg::REG_TARGET_ANGLE, '0},
    '{ROW_CHECKED, apbb_pkg::FUNC_TICK, 16'hff9c, apbb_pkg::REG_TARGET_ANGLE,
      '{8'sd0, 1'b1, 1'b0}},
    // crossed limits, target below both: only then clamped to min
    '{ROW_REG,     apbb_pkg::FUNC_TICK, 16'hff38, apbb_pkg::REG_TARGET_ANGLE, '0},
    '{ROW_BEAT,    apbb_pkg::FUNC_STOP, 16'h0000, apbb_pkg::REG_TARGET_ANGLE, '0},
    '{ROW_CHECKED, apbb_pkg::FUNC_TICK, 16'h0064, apbb_pkg::REG_TARGET_ANGLE,
      '{8'sd0, 1'b1, 1'b0}},
    // zero power drives nothing even far from target
    '{ROW_REG,     apbb_pkg::FUNC_TICK, 16'h0000, apbb_pkg::REG_DRIVE_POWER,  '0},
    '{ROW_BEAT,    apbb_pkg::FUNC_STOP, 16'h0000, apbb_pkg::REG_TARGET_ANGLE, '0},
    '{ROW_CHECKED, apbb_pkg::FUNC_TICK, 16'h1000, apbb_pkg::REG_TARGET_ANGLE,
      '{8'sd0, 1'b1, 1'b0}}
  };

  // Advance the controller model by one beat and return the held command
  function automatic cmd_t predict_arm_cmd(input logic fn,
                                           input logic signed [apbb_pkg::ANGLE_W-1:0] enc);
    int                                  err;
    logic signed [apbb_pkg::ANGLE_W-1:0] tgt;
    logic signed [apbb_pkg::CMD_W-1:0]   mag;
    logic                                at_check;
    logic                                stalled;
    cmd_t                                res;
    if (fn == apbb_pkg::FUNC_STOP) begin
      ctl.power_held = '0;
      ctl.brake_held = 1'b1;
      ctl.tick_count = '0;
      ctl.phase      = apbb_pkg::PH_LOAD;
      ctl.done_flag  = 1'b0;
    end else begin
      // latch target and power on the first tick of a move
      if (ctl.phase == apbb_pkg::PH_LOAD) begin
        tgt           = regs.target_angle;
        ctl.run_power = regs.drive_power;
        if (tgt > $signed(regs.limit_max)) begin
          tgt = regs.limit_max;
        end else if (tgt < $signed(regs.limit_min)) begin
          tgt = regs.limit_min;
        end
        ctl.clamped_target = tgt;
        ctl.phase          = apbb_pkg::PH_MOVE;
      end
      if (ctl.phase == apbb_pkg::PH_MOVE) begin
        err            = int'($signed(ctl.clamped_target)) - int'(enc);
        at_check       = (ctl.tick_count == apbb_pkg::TICK_W'(STALL_TICKS));
        stalled        = 1'b0;
        ctl.tick_count = ctl.tick_count + 1'b1;  // wraps in 7 bits
        // periodic stall check against the stored error
        if (at_check) begin
          if (apbb_pkg::ERR_W'(err) == ctl.last_error) begin
            ctl.power_held = '0;
            ctl.phase      = apbb_pkg::PH_DONE;
            stalled        = 1'b1;
          end else begin
            ctl.last_error = apbb_pkg::ERR_W'(err);
            ctl.tick_count = '0;
          end
        end
        if (!stalled) begin
          mag = {1'b0, ctl.run_power};
          if (err >= apbb_pkg::BAND_LO && err <= apbb_pkg::BAND_HI) begin
            ctl.power_held = '0;
            ctl.phase      = apbb_pkg::PH_DONE;
          end else if (err > apbb_pkg::BAND_HI) begin
            ctl.power_held = mag;
          end else begin
            ctl.power_held = -mag;
          end
        end
      end else if (ctl.phase == apbb_pkg::PH_DONE) begin
        ctl.brake_held = 1'b1;
        ctl.done_flag  = 1'b1;
      end
    end
    res.power = ctl.power_held;
    res.brake = ctl.brake_held;
    res.done  = ctl.done_flag;
    return res;
  endfunction

  function automatic logic signed [apbb_pkg::ANGLE_W-1:0] fit_angle(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return apbb_pkg::ANGLE_W'(v);
  endfunction

  function automatic logic signed [apbb_pkg::ANGLE_W-1:0] rand_angle();
    return apbb_pkg::ANGLE_W'($urandom);
  endfunction

  function automatic beat_t beat_of(input logic fn,
                                    input logic signed [apbb_pkg::ANGLE_W-1:0] enc);
    beat_t b;
    b.fn  = fn;
    b.enc = enc;
    return b;
  endfunction

  // Drive one beat, wait for it to be taken, then predict its command
  task automatic send_beat(input logic fn, input logic signed [apbb_pkg::ANGLE_W-1:0] enc,
                           output cmd_t predicted);
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= fn;
    in_ch.encoder_angle <= enc;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predicted = predict_arm_cmd(fn, enc);
  endtask

  // Stop sending and wait until every command has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [apbb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [apbb_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      apbb_pkg::REG_TARGET_ANGLE: regs.target_angle = val;
      apbb_pkg::REG_DRIVE_POWER:  regs.drive_power  = val[apbb_pkg::PWR_W-1:0];
      apbb_pkg::REG_LIMIT_MAX:    regs.limit_max    = val;
      apbb_pkg::REG_LIMIT_MIN:    regs.limit_min    = val;
      default: ;
    endcase
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Result side: check each accepted beat, then pick next ready
  initial begin
    cmd_t want;
    int   stall_left;
    stall_left    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_cmds.size() == 0) begin
          $display("%0t: unexpected result beat: power %0d brake %0b finished %0b",
                   $time, out_ch.motor_power, out_ch.brake_on, out_ch.finished);
          fail_count++;
        end else begin
          want = pending_cmds.pop_front();
          if (out_ch.motor_power !== want.power) begin
            $display("%0t: motor_power expected %0d got %0d",
                     $time, $signed(want.power), out_ch.motor_power);
            fail_count++;
          end
          if (out_ch.brake_on !== want.brake) begin
            $display("%0t: brake_on expected %0b got %0b", $time, want.brake, out_ch.brake_on);
            fail_count++;
          end
          if (out_ch.finished !== want.done) begin
            $display("%0t: finished expected %0b got %0b", $time, want.done, out_ch.finished);
            fail_count++;
          end
        end
      end
      // stall bursts
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        stall_left    = $urandom_range(1, 19) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    step_row_t                           row;
    cmd_t                                got;
    beat_t                               plan[$];
    int                                  a;
    int                                  b;
    int                                  lo;
    int                                  hi;
    int                                  aim;
    int                                  pos;
    int                                  random_sent;
    logic signed [apbb_pkg::ANGLE_W-1:0] hold;
    logic signed [apbb_pkg::ANGLE_W-1:0] enc;
    bit                                  jitter;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= apbb_pkg::REG_TARGET_ANGLE;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.func          <= apbb_pkg::FUNC_TICK;
    in_ch.encoder_angle <= '0;
    regs.target_angle    = apbb_pkg::TARGET_RST;
    regs.drive_power     = apbb_pkg::DRIVE_PWR_RST;
    regs.limit_max       = apbb_pkg::LIMIT_MAX_RST;
    regs.limit_min       = apbb_pkg::LIMIT_MIN_RST;
    ctl                  = '0;
    fail_count           = 0;
    src_gap_pct          = 20;
    sink_stall_pct       = 20;
    random_sent          = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int i = 0; i < $size(directed_rows); i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        settle();
        write_reg(row.idx, row.value);
      end else begin
        send_beat(row.fn, row.value, got);
        pending_cmds.push_back(row.kind == ROW_CHECKED ? row.want : got);
      end
    end

    // Random phases, each with its own settings
    while (random_sent < RANDOM_ITEMS) begin
      settle();

      case ($urandom_range(0, 7))
        0:       a = -32768;
        1:       a = 32767;
        2:       a = int'($urandom_range(0, 400)) - 200;
        default: a = rand_angle();
      endcase
      write_reg(apbb_pkg::REG_TARGET_ANGLE, apbb_pkg::CFG_DATA_W'(a));

      case ($urandom_range(0, 7))
        0:       b = 0;
        1:       b = 100;
        2:       b = 127;
        3:       b = 1;
        default: b = $urandom_range(0, 127);
      endcase
      write_reg(apbb_pkg::REG_DRIVE_POWER, apbb_pkg::CFG_DATA_W'(b));

      a = rand_angle();
      b = rand_angle();
      case ($urandom_range(0, 5))
        0: begin
          lo = -32768;
          hi = 32767;
        end
        1: begin  // min above max
          hi = (a < b) ? a : b;
          lo = (a < b) ? b : a;
        end
        default: begin
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
        end
      endcase
      write_reg(apbb_pkg::REG_LIMIT_MAX, apbb_pkg::CFG_DATA_W'(hi));
      write_reg(apbb_pkg::REG_LIMIT_MIN, apbb_pkg::CFG_DATA_W'(lo));

      // where the arm should end up under these settings
      aim = $signed(regs.target_angle);
      if (aim > $signed(regs.limit_max)) begin
        aim = $signed(regs.limit_max);
      end else if (aim < $signed(regs.limit_min)) begin
        aim = $signed(regs.limit_min);
      end

      if (random_sent < RANDOM_ITEMS - QUIET_TAIL) begin
        src_gap_pct    = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(3, 30));
        sink_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(3, 30));
      end

      // Build the phase out of move sequences
      plan.delete();
      hold = rand_angle();
      while (plan.size() < PHASE_ITEMS) begin
        a = $urandom_range(0, 99);
        if (a < 45) begin
          // approach: converge on the target, then sit in the done phase
          plan.push_back(beat_of(apbb_pkg::FUNC_STOP, rand_angle()));
          pos = rand_angle();
          repeat ($urandom_range(8, 40)) begin
            plan.push_back(beat_of(apbb_pkg::FUNC_TICK, fit_angle(pos)));
            pos = fit_angle(pos + (aim - pos) * int'($urandom_range(1, 3)) / 4
                            + int'($urandom_range(0, 2)) - 1);
          end
        end else if (a < 65) begin
          // hover around the dead band
          plan.push_back(beat_of(apbb_pkg::FUNC_STOP, rand_angle()));
          repeat ($urandom_range(3, 15)) begin
            plan.push_back(beat_of(apbb_pkg::FUNC_TICK,
                                   fit_angle(aim + int'($urandom_range(0, 10)) - 5)));
          end
        end else if (a < 78) begin
          // stuck arm: same reading long enough to reach the stall checks
          plan.push_back(beat_of(apbb_pkg::FUNC_STOP, hold));
          jitter = ($urandom_range(0, 3) == 0);
          repeat ($urandom_range(0, 1) ? 130 : 255) begin
            enc = hold;
            if (jitter && $urandom_range(0, 9) == 0) begin
              enc = fit_angle(hold + int'($urandom_range(1, 3)));
            end
            plan.push_back(beat_of(apbb_pkg::FUNC_TICK, enc));
          end
        end else begin
          // noise: stray stops and readings
          repeat ($urandom_range(1, 20)) begin
            enc = $urandom_range(0, 1) ? rand_angle()
                                       : fit_angle(aim + int'($urandom_range(0, 80)) - 40);
            plan.push_back(beat_of(($urandom_range(0, 3) == 0) ? apbb_pkg::FUNC_STOP
                                                               : apbb_pkg::FUNC_TICK, enc));
          end
        end
      end

      foreach (plan[k]) begin
        if (random_sent >= RANDOM_ITEMS) begin
          break;
        end
        if (random_sent >= RANDOM_ITEMS - QUIET_TAIL) begin
          src_gap_pct    = 0;
          sink_stall_pct = 0;
        end
        send_beat(plan[k].fn, plan[k].enc, got);
        pending_cmds.push_back(got);
        random_sent++;
      end
    end

    // Drain, then give stray beats a chance to show up
    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
